// ===== rtl/spq_pkg.sv =====
// Shared types and constants for the strict priority ECN queue.
// No dependencies.
`default_nettype none
package spq_pkg;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    ST_ENQ        = 3'd0,
    ST_DROP_LIMIT = 3'd1,
    ST_DROP_FULL  = 3'd2,
    ST_DEQ        = 3'd3,
    ST_EMPTY      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    REG_QUEUES = 3'd0,
    REG_LIMIT  = 3'd1,
    REG_MEAN   = 3'd2,
    REG_THRESH = 3'd3,
    REG_RMAX   = 3'd4,
    REG_PMAX   = 3'd5,
    REG_MODE   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_QUEUE = 2'd1,
    MODE_PORT  = 2'd2,
    MODE_RED   = 2'd3
  } mark_mode_t;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic        deq;
    logic [3:0]  prio;
    logic [15:0] bytes;
    logic [31:0] tag;
    logic        ect;
    logic        ce;
    logic [15:0] rnd;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/strict_priority_ecn_queue.sv =====
// Top level of the strict priority ECN queue: configuration registers,
// command front part and scheduling back part. Depends on spq_pkg.
//
// Usage: raise start with one command (cmd 0 enqueue, 1 dequeue) while busy
// is low. Each command gives exactly one result on status, out_tag,
// out_bytes, out_ce and out_queue, marked by done for one cycle; the
// receiver cannot stall. With the back part idle, an enqueue or a dequeue
// that finds a packet passes through front hand-off, threshold products,
// RED products or descriptor read, and update, then raises done; a dequeue
// that finds every queue empty raises done in the descriptor read step.
// The back part takes one command at a time and takes the next only once
// it is back in idle. The front holds up to two commands and raises busy
// only when both entries are taken.
// Configuration registers are written through cfg_we, cfg_idx, cfg_data
// while the block is idle. Reset clears all queues and counters and loads
// the register defaults; descriptor memory is not cleared.
`default_nettype none
module strict_priority_ecn_queue #(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_WIDTH   = 16
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire                             cmd,
  input  wire [3:0]                       class_prio,
  input  wire [15:0]                      packet_bytes,
  input  wire [15:0]                      packet_tag,
  input  wire                             ecn_capable,
  input  wire                             ce_in,
  input  wire [15:0]                      random_q16,
  input  wire                             cfg_we,
  input  wire [spq_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire [spq_pkg::CFG_W-1:0]        cfg_data,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [15:0]                     out_tag,
  output logic [15:0]                     out_bytes,
  output logic                            out_ce,
  output logic [2:0]                      out_queue
);
  import spq_pkg::*;

  logic [3:0]  queues_in_use;
  logic [15:0] limit_packets, mean_packet_bytes, mark_thresh_packets;
  logic [15:0] red_max_packets, red_pmax_q16;
  logic [1:0]  mark_mode;
  logic        avail, pop;
  cmd_t        head;

  always_ff @(posedge clk) begin
    if (rst) begin
      queues_in_use <= 4'd8;
      limit_packets <= 16'd1000;
      mean_packet_bytes <= 16'd1500;
      mark_thresh_packets <= 16'd65;
      red_max_packets <= 16'd65;
      red_pmax_q16 <= 16'hFFFF;
      mark_mode <= MODE_OFF;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_QUEUES: queues_in_use <= cfg_data[3:0];
        REG_LIMIT:  limit_packets <= cfg_data;
        REG_MEAN:   mean_packet_bytes <= cfg_data;
        REG_THRESH: mark_thresh_packets <= cfg_data;
        REG_RMAX:   red_max_packets <= cfg_data;
        REG_PMAX:   red_pmax_q16 <= cfg_data;
        REG_MODE:   mark_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  spq_front u_front (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .class_prio(class_prio),
    .packet_bytes(packet_bytes), .packet_tag(packet_tag),
    .ecn_capable(ecn_capable), .ce_in(ce_in), .random_q16(random_q16),
    .pop(pop), .busy(busy), .avail(avail), .head(head)
  );

  spq_back #(
    .MAX_QUEUES(MAX_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH), .TAG_WIDTH(TAG_WIDTH)
  ) u_back (
    .clk(clk), .rst(rst), .avail(avail), .head(head), .pop(pop),
    .cfg_queues(queues_in_use), .cfg_limit(limit_packets),
    .cfg_mean(mean_packet_bytes), .cfg_thresh(mark_thresh_packets),
    .cfg_rmax(red_max_packets), .cfg_pmax(red_pmax_q16), .cfg_mode(mark_mode),
    .done(done), .status(status), .out_tag(out_tag), .out_bytes(out_bytes),
    .out_ce(out_ce), .out_queue(out_queue)
  );
endmodule
`default_nettype wire

// ===== rtl/spq_front.sv =====
// Front part: latches commands and holds them in a two-entry queue.
// Depends on spq_pkg.
`default_nettype none
module spq_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire                 cmd,
  input  wire [3:0]           class_prio,
  input  wire [15:0]          packet_bytes,
  input  wire [15:0]          packet_tag,
  input  wire                 ecn_capable,
  input  wire                 ce_in,
  input  wire [15:0]          random_q16,
  input  wire                 pop,
  output logic                busy,
  output logic                avail,
  output spq_pkg::cmd_t       head
);
  import spq_pkg::*;

  cmd_t fifo [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push;
  cmd_t c;

  always_comb begin
    c = '0;
    c.deq = cmd;
    c.prio = class_prio;
    c.bytes = packet_bytes;
    c.tag = 32'(packet_tag);
    c.ect = ecn_capable;
    c.ce = ce_in;
    c.rnd = random_q16;
  end

  assign busy = (cnt == 2'd2);
  assign push = start && !busy;
  assign avail = (cnt != 2'd0);
  assign head = fifo[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= c;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/spq_back.sv =====
// Back part: queue state, descriptor memory, marking and dequeue selection.
// Depends on spq_pkg.
`default_nettype none
module spq_back #(
  parameter int MAX_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64,
  parameter int TAG_WIDTH   = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 avail,
  input  spq_pkg::cmd_t       head,
  output logic                pop,
  input  wire [3:0]           cfg_queues,
  input  wire [15:0]          cfg_limit,
  input  wire [15:0]          cfg_mean,
  input  wire [15:0]          cfg_thresh,
  input  wire [15:0]          cfg_rmax,
  input  wire [15:0]          cfg_pmax,
  input  wire [1:0]           cfg_mode,
  output logic                done,
  output logic [2:0]          status,
  output logic [15:0]         out_tag,
  output logic [15:0]         out_bytes,
  output logic                out_ce,
  output logic [2:0]          out_queue
);
  import spq_pkg::*;

  localparam int QW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int DW = TAG_WIDTH + 17;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_MUL  = 5'b00100,
    S_MUL2 = 5'b01000,
    S_READ = 5'b10000
  } state_t;

  state_t state;
  cmd_t cur;
  logic [DW-1:0] mem [MAX_QUEUES << PW];
  logic [DW-1:0] rdata;
  logic [PW-1:0] qhead [MAX_QUEUES];
  logic [PW-1:0] qtail [MAX_QUEUES];
  logic [CW-1:0] qcnt [MAX_QUEUES];
  logic [31:0]   qbytes [MAX_QUEUES];
  logic [31:0]   total;
  logic [31:0]   tnew;

  logic [QW-1:0] q;
  logic [4:0]    nq;
  logic [31:0]   lo, hi, limit;
  logic [31:0]   lhs_a;
  logic [48:0]   lhs;
  logic [47:0]   rhs;
  logic          drop_lim, drop_full, ramp;
  logic          found;
  logic [QW-1:0] sel;
  logic [QW-1:0] wq;

  always_comb begin
    nq = {1'b0, cfg_queues};
    if (nq > 5'(MAX_QUEUES)) nq = 5'(MAX_QUEUES);
    if (nq == 5'd0) nq = 5'd1;
  end

  always_comb begin
    logic [4:0] p;
    p = {1'b0, cur.prio};
    if (p >= nq) p = nq - 5'd1;
    q = p[QW-1:0];
  end

  always_comb begin
    found = 1'b0;
    sel = '0;
    for (int i = MAX_QUEUES - 1; i >= 0; i--) begin
      if (5'(i) < nq && qcnt[i] != '0) begin
        found = 1'b1;
        sel = QW'(i);
      end
    end
  end

  assign tnew = total + 32'(cur.bytes);
  assign drop_lim = ({1'b0, total} + 33'(cur.bytes)) > {1'b0, limit};
  assign drop_full = (qcnt[q] >= CW'(QUEUE_DEPTH));
  assign pop = (state == S_IDLE) && avail;

  always_ff @(posedge clk) begin
    logic mark;
    logic oce;
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        qhead[i] <= '0;
        qtail[i] <= '0;
        qcnt[i] <= '0;
        qbytes[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (avail) begin
            cur <= head;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          lo <= 32'(cfg_thresh) * 32'(cfg_mean);
          hi <= 32'(cfg_rmax) * 32'(cfg_mean);
          limit <= 32'(cfg_limit) * 32'(cfg_mean);
          state <= S_MUL;
        end
        S_MUL: begin
          if (cur.deq) begin
            wq <= sel;
            if (!found) begin
              status <= ST_EMPTY;
              out_tag <= '0;
              out_bytes <= '0;
              out_ce <= 1'b0;
              out_queue <= '0;
              done <= 1'b1;
              state <= S_IDLE;
            end else begin
              rdata <= mem[{sel, qhead[sel]}];
              state <= S_READ;
            end
          end else begin
            lhs_a <= 32'(cur.rnd) * 32'(cfg_rmax - cfg_thresh);
            rhs <= 48'(cfg_pmax) * 48'(tnew - lo);
            ramp <= (tnew > lo) && (cfg_rmax > cfg_thresh);
            state <= S_MUL2;
          end
        end
        S_MUL2: begin
          // second product step happens combinationally below via lhs
          out_tag <= '0;
          out_bytes <= '0;
          out_queue <= 3'(q);
          done <= 1'b1;
          state <= S_IDLE;
          if (drop_lim) begin
            status <= ST_DROP_LIMIT;
            out_ce <= 1'b0;
          end else if (drop_full) begin
            status <= ST_DROP_FULL;
            out_ce <= 1'b0;
          end else begin
            case (cfg_mode)
              MODE_QUEUE: mark = (qbytes[q] + 32'(cur.bytes)) > lo;
              MODE_PORT:  mark = tnew > lo;
              MODE_RED:   mark = (tnew > hi) || (ramp && (lhs < {1'b0, rhs}));
              default:    mark = 1'b0;
            endcase
            oce = cur.ce | (mark & cur.ect);
            mem[{q, qtail[q]}] <= {cur.tag[TAG_WIDTH-1:0], cur.bytes, oce};
            qtail[q] <= (qtail[q] == PW'(QUEUE_DEPTH - 1)) ? '0 : qtail[q] + 1'b1;
            qcnt[q] <= qcnt[q] + 1'b1;
            qbytes[q] <= qbytes[q] + 32'(cur.bytes);
            total <= tnew;
            status <= ST_ENQ;
            out_ce <= oce;
          end
        end
        S_READ: begin
          qhead[wq] <= (qhead[wq] == PW'(QUEUE_DEPTH - 1)) ? '0 : qhead[wq] + 1'b1;
          qcnt[wq] <= qcnt[wq] - 1'b1;
          qbytes[wq] <= qbytes[wq] - 32'(rdata[16:1]);
          total <= total - 32'(rdata[16:1]);
          status <= ST_DEQ;
          out_tag <= 16'(rdata[DW-1:17]);
          out_bytes <= rdata[16:1];
          out_ce <= rdata[0];
          out_queue <= 3'(wq);
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign lhs = 49'(lhs_a) * 49'(cfg_mean);
endmodule
`default_nettype wire

// ===== bench/tb_strict_priority_ecn_queue.sv =====
// Self-checking bench for strict_priority_ecn_queue: random and directed enqueue/dequeue
// commands checked against an in-bench scheduler model. Depends on spq_pkg and the RTL top.
module tb_strict_priority_ecn_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int NQ = 8;
  localparam int DEPTH = 64;

  typedef struct {
    logic        cmd;
    logic [3:0]  prio;
    logic [15:0] bytes;
    logic [15:0] tag;
    logic        ect;
    logic        ce;
    logic [15:0] rnd;
  } item_t;

  typedef struct {
    status_t     st;
    logic [15:0] tag;
    logic [15:0] bytes;
    logic        ce;
    logic [2:0]  q;
  } result_t;

  logic clk = 0, rst = 1;
  logic start = 0, cmd = 0, ecn_capable = 0, ce_in = 0, cfg_we = 0;
  logic [3:0] class_prio = 0;
  logic [15:0] packet_bytes = 0, packet_tag = 0, random_q16 = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = 0;
  logic [CFG_W-1:0] cfg_data = 0;
  logic busy, done, out_ce;
  logic [2:0] status, out_queue;
  logic [15:0] out_tag, out_bytes;

  strict_priority_ecn_queue u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .class_prio(class_prio), .packet_bytes(packet_bytes), .packet_tag(packet_tag),
    .ecn_capable(ecn_capable), .ce_in(ce_in), .random_q16(random_q16),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .done(done),
    .status(status), .out_tag(out_tag), .out_bytes(out_bytes), .out_ce(out_ce),
    .out_queue(out_queue)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // scheduler model state
  logic [15:0] m_tag [NQ][DEPTH];
  logic [15:0] m_bytes [NQ][DEPTH];
  logic        m_ce [NQ][DEPTH];
  int unsigned m_head [NQ], m_tail [NQ], m_count [NQ];
  longint unsigned m_qbytes [NQ];
  longint unsigned m_total;
  logic [3:0]  r_queues;
  logic [15:0] r_limit, r_mean, r_thresh, r_rmax, r_pmax;
  mark_mode_t  r_mode;

  item_t   pending_items[$];
  result_t expected_results[$];
  int errors = 0, accepted = 0, checked = 0;
  bit idle_enable = 1;
  int gap = 0;
  item_t cur_item;
  logic busy_s = 0;

  function automatic bit mark_decision(int q, longint unsigned rnd);
    longint unsigned lo, hi;
    lo = longint'(r_thresh) * r_mean;
    hi = longint'(r_rmax) * r_mean;
    case (r_mode)
      MODE_QUEUE: return m_qbytes[q] > lo;
      MODE_PORT:  return m_total > lo;
      MODE_RED: begin
        if (m_total > hi) return 1;
        if (m_total > lo && r_rmax > r_thresh)
          return rnd * longint'(r_rmax - r_thresh) * r_mean < longint'(r_pmax) * (m_total - lo);
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic result_t schedule_item(item_t it);
    result_t r;
    int nq, q;
    r = '{ST_EMPTY, 0, 0, 0, 0};
    nq = (r_queues > NQ) ? NQ : (r_queues < 1 ? 1 : r_queues);
    if (!it.cmd) begin
      q = (it.prio >= nq) ? nq - 1 : it.prio;
      r.q = 3'(q);
      if (m_total + it.bytes > longint'(r_limit) * r_mean) r.st = ST_DROP_LIMIT;
      else if (m_count[q] >= DEPTH) r.st = ST_DROP_FULL;
      else begin
        m_count[q]++;
        m_qbytes[q] += it.bytes;
        m_total += it.bytes;
        r.ce = it.ce | (mark_decision(q, it.rnd) & it.ect);
        m_tag[q][m_tail[q]] = it.tag;
        m_bytes[q][m_tail[q]] = it.bytes;
        m_ce[q][m_tail[q]] = r.ce;
        m_tail[q] = (m_tail[q] + 1) % DEPTH;
        r.st = ST_ENQ;
      end
    end else begin
      for (int i = 0; i < nq; i++) begin
        if (m_count[i] > 0) begin
          r.tag = m_tag[i][m_head[i]];
          r.bytes = m_bytes[i][m_head[i]];
          r.ce = m_ce[i][m_head[i]];
          r.q = 3'(i);
          r.st = ST_DEQ;
          m_head[i] = (m_head[i] + 1) % DEPTH;
          m_count[i]--;
          m_qbytes[i] -= r.bytes;
          m_total -= r.bytes;
          break;
        end
      end
    end
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_s) begin
        expected_results.push_back(schedule_item(cur_item));
        accepted++;
      end
      if (start && busy_s) begin
      end else if (gap > 0) begin
        gap--;
        start <= 0;
      end else if (idle_enable && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 11) - 1;
        start <= 0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        start <= 1;
        cmd <= cur_item.cmd;
        class_prio <= cur_item.prio;
        packet_bytes <= cur_item.bytes;
        packet_tag <= cur_item.tag;
        ecn_capable <= cur_item.ect;
        ce_in <= cur_item.ce;
        random_q16 <= cur_item.rnd;
      end else begin
        start <= 0;
      end
    end
  end

  always @(posedge clk) busy_s <= busy;

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      result_t e;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result status=%0d tag=%h", $realtime, status, out_tag);
        errors++;
      end else begin
        e = expected_results.pop_front();
        checked++;
        if (status !== e.st || out_tag !== e.tag || out_bytes !== e.bytes ||
            out_ce !== e.ce || out_queue !== e.q) begin
          $display("%0t mismatch exp st=%0d tag=%h bytes=%h ce=%b q=%0d",
                   $realtime, e.st, e.tag, e.bytes, e.ce, e.q);
          $display("%0t          act st=%0d tag=%h bytes=%h ce=%b q=%0d",
                   $realtime, status, out_tag, out_bytes, out_ce, out_queue);
          errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      REG_QUEUES: r_queues = val[3:0];
      REG_LIMIT:  r_limit = val;
      REG_MEAN:   r_mean = val;
      REG_THRESH: r_thresh = val;
      REG_RMAX:   r_rmax = val;
      REG_PMAX:   r_pmax = val;
      default:    r_mode = mark_mode_t'(val[1:0]);
    endcase
  endtask

  task automatic add_item(logic c, logic [3:0] p, logic [15:0] b, logic [15:0] t,
                          logic e, logic ce, logic [15:0] rn);
    pending_items.push_back('{c, p, b, t, e, ce, rn});
  endtask

  task automatic add_random(int n, int deq_pct, int max_bytes);
    repeat (n)
      add_item($urandom_range(0, 99) < deq_pct, 4'($urandom_range(0, 15)),
               ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(0, max_bytes)),
               16'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               16'($urandom));
  endtask

  initial begin
    for (int i = 0; i < NQ; i++) begin
      m_head[i] = 0; m_tail[i] = 0; m_count[i] = 0; m_qbytes[i] = 0;
    end
    m_total = 0;
    r_queues = 8; r_limit = 1000; r_mean = 1500; r_thresh = 65; r_rmax = 65;
    r_pmax = 65535; r_mode = MODE_OFF;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty, extremes, enqueue, dequeue and full-queue drop
    add_item(1, 0, 0, 0, 0, 0, 0);
    add_item(0, 15, 16'hFFFF, 16'hFFFF, 1, 1, 16'hFFFF);
    add_item(0, 0, 0, 16'h0000, 0, 0, 0);
    add_item(0, 3, 100, 16'hA5A5, 1, 0, 0);
    add_item(1, 0, 0, 0, 0, 0, 0);
    add_item(1, 0, 0, 0, 0, 0, 0);
    add_item(1, 0, 0, 0, 0, 0, 0);
    add_item(1, 0, 0, 0, 0, 0, 0);
    wait_drained();
    write_reg(REG_LIMIT, 16'hFFFF);
    write_reg(REG_MEAN, 16'hFFFF);
    write_reg(REG_QUEUES, 1);
    repeat (66) add_item(0, 5, 16'($urandom), 16'($urandom), 1, 0, 0);
    add_item(1, 0, 0, 0, 0, 0, 0);
    wait_drained();
    write_reg(REG_QUEUES, 0);
    repeat (70) add_item(1, 0, 0, 0, 0, 0, 0);
    wait_drained();

    // random phases across marking modes and limits
    write_reg(REG_QUEUES, 8); write_reg(REG_MEAN, 100); write_reg(REG_LIMIT, 300);
    write_reg(REG_THRESH, 20); write_reg(REG_MODE, MODE_QUEUE);
    add_random(160, 40, 1000);
    wait_drained();
    write_reg(REG_MODE, MODE_PORT); write_reg(REG_QUEUES, 3);
    add_random(160, 45, 1000);
    wait_drained();
    write_reg(REG_MODE, MODE_RED); write_reg(REG_QUEUES, 15); write_reg(REG_THRESH, 10);
    write_reg(REG_RMAX, 200); write_reg(REG_PMAX, 40000); write_reg(REG_LIMIT, 400);
    add_random(200, 45, 1000);
    wait_drained();
    write_reg(REG_THRESH, 0); write_reg(REG_PMAX, 0); write_reg(REG_RMAX, 65535);
    write_reg(REG_MEAN, 1); write_reg(REG_LIMIT, 0);
    add_random(60, 50, 10);
    wait_drained();
    write_reg(REG_MEAN, 65535); write_reg(REG_LIMIT, 65535); write_reg(REG_PMAX, 65535);
    write_reg(REG_THRESH, 65535); write_reg(REG_MODE, MODE_OFF);
    idle_enable = 0;
    add_random(160, 50, 65535);
    wait_drained();

    $display("covered %0d commands over all marking modes, drops and queue counts", accepted);
    $display("%0d results checked", checked);
    if (errors == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
